// ----- hdl/cad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cad_pkg
// Shared types and constants for the cartridge address decoder.
// ----------------------------------------------------------------------------
package cad_pkg;

  localparam int AddrW     = 24;
  localparam int RomOffW   = 23;
  localparam int SramOffW  = 19;
  localparam int RomSizeW  = 24;
  localparam int SramSizeW = 20;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 24;
  // back pipeline depth, at most one conditional subtract per stage
  localparam int ModStages = RomOffW;

  typedef enum logic [1:0] {
    MODE_LOROM   = 2'd0,
    MODE_HIROM   = 2'd1,
    MODE_EXHIROM = 2'd2,
    MODE_NONE    = 2'd3
  } map_mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP_MODE  = 2'd0,
    REG_ROM_SIZE  = 2'd1,
    REG_SRAM_SIZE = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

  // one classified request with unwrapped offsets
  typedef struct packed {
    logic                rom_hit;
    logic [RomOffW-1:0]  rom_raw;
    logic                sram_hit;
    logic [SramOffW-1:0] sram_raw;
  } item_t;

endpackage
`default_nettype wire

// ----- hdl/cad_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cad_front
// Classifies a bus address into ROM and save-RAM windows and forms raw offsets.
// ----------------------------------------------------------------------------
module cad_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic                           advance,
  input  wire logic [cad_pkg::AddrW-1:0]      cpu_address,
  input  wire cad_pkg::map_mode_t             map_mode,
  input  wire logic                           rom_present,
  input  wire logic                           sram_present,
  output logic                                valid,
  output cad_pkg::item_t                      item
);

  logic           valid_r, valid_nxt;
  cad_pkg::item_t item_r;
  cad_pkg::item_t item_nxt;
  logic [7:0]     b;
  logic [15:0]    o;
  logic           mirror, system, lo_sram_bank, hi_sram_bank, window;

  assign b = cpu_address[23:16];
  assign o = cpu_address[15:0];

  // bank and offset windows
  always_comb begin
    mirror       = (b >= 8'h40 && b <= 8'h7d) || b >= 8'hc0;
    system       = b <= 8'h3f || (b >= 8'h80 && b <= 8'hbf);
    lo_sram_bank = (b >= 8'h70 && b <= 8'h7d) || b >= 8'hf0;
    hi_sram_bank = (b >= 8'h20 && b <= 8'h3f) || (b >= 8'ha0 && b <= 8'hbf);
    window       = o >= 16'h6000 && o <= 16'h7fff;
  end

  // layout decode
  always_comb begin
    item_nxt = '0;
    unique case (map_mode)
      cad_pkg::MODE_LOROM: begin
        item_nxt.rom_hit = o[15] || mirror;
        item_nxt.rom_raw = {1'b0, b[6:0], o[14:0]};
        if (lo_sram_bank && !o[15]) begin
          item_nxt.sram_hit = 1'b1;
          item_nxt.sram_raw = {b[3:0], o[14:0]};
        end else if (system && window) begin
          item_nxt.sram_hit = 1'b1;
          item_nxt.sram_raw = {b[5:0], o[12:0]};
        end
      end
      cad_pkg::MODE_HIROM: begin
        item_nxt.rom_hit  = o[15] || mirror;
        item_nxt.rom_raw  = {1'b0, b[5:0], o};
        item_nxt.sram_hit = hi_sram_bank && window;
        item_nxt.sram_raw = {1'b0, b[4:0], o[12:0]};
      end
      cad_pkg::MODE_EXHIROM: begin
        item_nxt.rom_hit  = b >= 8'hc0 || (b >= 8'h40 && b <= 8'h7d) || o[15];
        item_nxt.rom_raw  = {!(b >= 8'hc0), b[5:0], o};
        item_nxt.sram_hit = hi_sram_bank && window;
        item_nxt.sram_raw = {1'b0, b[4:0], o[12:0]};
      end
      default: item_nxt = '0;
    endcase
    item_nxt.rom_hit  = item_nxt.rom_hit && rom_present;
    item_nxt.sram_hit = item_nxt.sram_hit && sram_present;
  end

  // stage register, holds while the queue is full
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule
`default_nettype wire

// ----- hdl/cad_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cad_fifo
// Two-entry queue between the decode front and the wrap pipeline.
// ----------------------------------------------------------------------------
module cad_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cad_pkg::item_t push_item,
  output logic                full,
  output logic                pop,
  output cad_pkg::item_t      pop_item
);

  cad_pkg::item_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push;

  assign full    = count_r == 2'd2;
  assign pop     = count_r != 2'd0;
  assign do_push = push && !full;
  assign pop_item = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cad_mod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cad_mod
// Pipelined restoring remainder: at most one shifted compare and subtract per stage.
// ----------------------------------------------------------------------------
module cad_mod #(
  parameter int RAW_W  = cad_pkg::RomOffW,
  parameter int SIZE_W = cad_pkg::RomSizeW,
  parameter int STAGES = cad_pkg::ModStages
) (
  input  wire logic              clk,
  input  wire logic              in_hit,
  input  wire logic [RAW_W-1:0]  in_raw,
  input  wire logic [SIZE_W-1:0] size,
  output logic                   out_hit,
  output logic [RAW_W-1:0]       out_offset
);

  localparam int W = SIZE_W + RAW_W;

  logic [RAW_W-1:0] rem_r [STAGES];
  logic             hit_r [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic [RAW_W-1:0] rem_in, rem_nxt;
    logic             hit_in;
    if (j == 0) begin : g_first
      assign rem_in = in_raw;
      assign hit_in = in_hit;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign hit_in = hit_r[j-1];
    end
    // subtract size shifted to the bit this stage resolves
    if (j < RAW_W) begin : g_sub
      logic [W-1:0] div_sh, rem_ext;
      assign div_sh  = W'(size) << (RAW_W - 1 - j);
      assign rem_ext = W'(rem_in);
      assign rem_nxt = (rem_ext >= div_sh) ? RAW_W'(rem_ext - div_sh) : rem_in;
    end else begin : g_pass
      assign rem_nxt = rem_in;
    end
    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      hit_r[j] <= hit_in;
    end
  end

  // a miss reports offset zero
  assign out_hit    = hit_r[STAGES-1];
  assign out_offset = hit_r[STAGES-1] ? rem_r[STAGES-1] : '0;

endmodule
`default_nettype wire

// ----- hdl/cad_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cad_back
// Wraps both raw offsets by their configured sizes and strobes the result.
// ----------------------------------------------------------------------------
module cad_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire cad_pkg::item_t                    in_item,
  input  wire logic [cad_pkg::RomSizeW-1:0]      rom_size,
  input  wire logic [cad_pkg::SramSizeW-1:0]     sram_size,
  output logic                                   out_valid,
  output logic                                   out_rom_hit,
  output logic [cad_pkg::RomOffW-1:0]            out_rom_offset,
  output logic                                   out_sram_hit,
  output logic [cad_pkg::SramOffW-1:0]           out_sram_offset
);

  logic [cad_pkg::ModStages-1:0] valid_r, valid_nxt;

  // valid travels alongside the data stages
  assign valid_nxt = {valid_r[cad_pkg::ModStages-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r[cad_pkg::ModStages-1];

  cad_mod #(
    .RAW_W  (cad_pkg::RomOffW),
    .SIZE_W (cad_pkg::RomSizeW),
    .STAGES (cad_pkg::ModStages)
  ) u_rom_mod (
    .clk        (clk),
    .in_hit     (in_item.rom_hit),
    .in_raw     (in_item.rom_raw),
    .size       (rom_size),
    .out_hit    (out_rom_hit),
    .out_offset (out_rom_offset)
  );

  cad_mod #(
    .RAW_W  (cad_pkg::SramOffW),
    .SIZE_W (cad_pkg::SramSizeW),
    .STAGES (cad_pkg::ModStages)
  ) u_sram_mod (
    .clk        (clk),
    .in_hit     (in_item.sram_hit),
    .in_raw     (in_item.sram_raw),
    .size       (sram_size),
    .out_hit    (out_sram_hit),
    .out_offset (out_sram_offset)
  );

endmodule
`default_nettype wire

// ----- hdl/cartridge_address_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_address_decoder_core
// Translates a bus address into wrapped ROM and save-RAM offsets.
// ----------------------------------------------------------------------------
// one request per cycle while busy is low; the result strobes once for each start taken
// result path: decode register, queue slot, then 23 remainder stages (one bit each)
// busy stays low since the result side never stalls the queue
// synchronous active-low reset clears config and all valid flags
module cartridge_address_decoder_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [cad_pkg::AddrW-1:0]        in_cpu_address,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cad_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [cad_pkg::CfgDataW-1:0]     cfg_data,
  output logic                                  out_valid,
  output logic                                  out_rom_hit,
  output logic [cad_pkg::RomOffW-1:0]           out_rom_offset,
  output logic                                  out_sram_hit,
  output logic [cad_pkg::SramOffW-1:0]          out_sram_offset
);

  cad_pkg::map_mode_t                  map_mode_r, map_mode_nxt;
  logic [cad_pkg::RomSizeW-1:0]        rom_size_r, rom_size_nxt;
  logic [cad_pkg::SramSizeW-1:0]       sram_size_r, sram_size_nxt;
  logic                                accept, f_valid, q_full, q_pop;
  cad_pkg::item_t                      f_item, q_item;

  // config registers
  assign cfg_ready = 1'b1;

  always_comb begin
    map_mode_nxt  = map_mode_r;
    rom_size_nxt  = rom_size_r;
    sram_size_nxt = sram_size_r;
    if (cfg_valid) begin
      unique case (cad_pkg::cfg_reg_t'(cfg_index))
        cad_pkg::REG_MAP_MODE:  map_mode_nxt  = cad_pkg::map_mode_t'(cfg_data[1:0]);
        cad_pkg::REG_ROM_SIZE:  rom_size_nxt  = cfg_data[cad_pkg::RomSizeW-1:0];
        cad_pkg::REG_SRAM_SIZE: sram_size_nxt = cfg_data[cad_pkg::SramSizeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r  <= cad_pkg::MODE_LOROM;
      rom_size_r  <= '0;
      sram_size_r <= '0;
    end else begin
      map_mode_r  <= map_mode_nxt;
      rom_size_r  <= rom_size_nxt;
      sram_size_r <= sram_size_nxt;
    end
  end

  // request handshake
  assign busy   = f_valid && q_full;
  assign accept = start && !busy;

  cad_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .advance      (!q_full),
    .cpu_address  (in_cpu_address),
    .map_mode     (map_mode_r),
    .rom_present  (rom_size_r != '0),
    .sram_present (sram_size_r != '0),
    .valid        (f_valid),
    .item         (f_item)
  );

  cad_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  cad_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (q_pop),
    .in_item         (q_item),
    .rom_size        (rom_size_r),
    .sram_size       (sram_size_r),
    .out_valid       (out_valid),
    .out_rom_hit     (out_rom_hit),
    .out_rom_offset  (out_rom_offset),
    .out_sram_hit    (out_sram_hit),
    .out_sram_offset (out_sram_offset)
  );

  // wrapped offsets stay below the configured size
  a_rom_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rom_hit |-> {1'b0, out_rom_offset} < rom_size_r)
    else $error("rom offset not below rom size");

  a_sram_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sram_hit |-> {1'b0, out_sram_offset} < sram_size_r)
    else $error("sram offset not below sram size");

  // queue drains every cycle, so the front never backs up
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("front stalled by full queue");

endmodule
`default_nettype wire
